// ===== rtl/core/footswitch_gesture_detector_unit_defines.svh =====
// Assertion macros shared by the footswitch gesture detector RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef FOOTSWITCH_GESTURE_DETECTOR_UNIT_DEFINES_SVH
`define FOOTSWITCH_GESTURE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FGD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fgd assertion failed");

// Next-cycle implication, checked outside reset.
`define FGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fgd assertion failed");

`endif

// ===== rtl/core/fgd_pkg.sv =====
// Types and constants of the footswitch gesture detector.
// No dependencies; imported by fgd_switch_update and the top level.
package fgd_pkg;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_NORMAL = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_code_t;

    localparam logic [1:0] CFG_IDX_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_IDX_MASK      = 2'd1;
    localparam logic [1:0] CFG_IDX_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_IDX_WINDOW    = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_MULTI = 3'd2;

    localparam logic [2:0]  MASK_RESET      = 3'd7;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
    localparam logic [15:0] WINDOW_RESET    = 16'd500;

    localparam int unsigned MASK_BIT_NORMAL = 0;
    localparam int unsigned MASK_BIT_DOUBLE = 1;
    localparam int unsigned MASK_BIT_LONG   = 2;

    // Per-switch tracking state.
    typedef struct packed {
        logic               prev_level;
        logic [TIME_W-1:0]  press_start_time;
        logic [TIME_W-1:0]  last_press_time;
        logic [COUNT_W-1:0] press_count;
        logic               long_fired;
    } sw_state_t;

    // Settings that steer event decoding.
    typedef struct packed {
        logic [2:0]  event_mask;
        logic [15:0] hold_limit_ms;
        logic [15:0] double_press_window_ms;
    } fgd_cfg_t;

endpackage

// ===== rtl/core/fgd_switch_update.sv =====
// Combinational gesture decode and state update for one footswitch tick.
// Depends on fgd_pkg.
module fgd_switch_update
    import fgd_pkg::*;
(
    input  sw_state_t         cur_state,
    input  fgd_cfg_t          cfg,
    input  logic              level,
    input  logic [TIME_W-1:0] now,
    output sw_state_t         nxt_state,
    output event_code_t       code
);

    logic              press;
    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
    logic              in_window;
    logic              long_hit;
    logic              short_hold;

    assign press      = level && !cur_state.prev_level;
    assign since_last = now - cur_state.last_press_time;
    assign in_window  = since_last <= {16'd0, cfg.double_press_window_ms};
    assign start_time = press ? now : cur_state.press_start_time;
    assign duration   = now - start_time;
    assign long_hit   = duration >= {16'd0, cfg.hold_limit_ms};
    assign short_hold = !long_hit;

    always_comb
    begin
        nxt_state = cur_state;
        code      = EV_NONE;

        if (press)
        begin
            nxt_state.press_start_time = now;
            nxt_state.last_press_time  = now;
            nxt_state.long_fired       = 1'b0;
            if (in_window)
            begin
                if (cur_state.press_count < COUNT_MAX)
                begin
                    nxt_state.press_count = cur_state.press_count + COUNT_ONE;
                end
            end
            else
            begin
                nxt_state.press_count = COUNT_ONE;
            end
        end

        // A hold that reaches the threshold fires the long press only once.
        if (level && long_hit && !nxt_state.long_fired)
        begin
            if (cfg.event_mask[MASK_BIT_LONG])
            begin
                code = EV_LONG;
            end
            nxt_state.long_fired = 1'b1;
        end

        // Release; nothing is reported after a long press.
        if (!level && cur_state.prev_level && !cur_state.long_fired)
        begin
            if (cur_state.press_count >= COUNT_MULTI)
            begin
                if (cfg.event_mask[MASK_BIT_DOUBLE])
                begin
                    code = EV_DOUBLE;
                end
                nxt_state.press_count = '0;
            end
            else if (short_hold && cfg.event_mask[MASK_BIT_NORMAL])
            begin
                code = EV_NORMAL;
            end
        end

        nxt_state.prev_level = level;
    end

endmodule

// ===== rtl/core/footswitch_gesture_detector_unit.sv =====
// Top level of the footswitch gesture detector: handshakes, settings and per-switch state.
// Depends on fgd_pkg, fgd_switch_update and footswitch_gesture_detector_unit_defines.svh.
//
// Each input beat is one control tick for one footswitch: the debounced level and a
// wrapping millisecond time stamp. Every accepted beat produces exactly one output beat,
// carrying event_code (0 none, 1 normal press, 2 double press, 3 long press) and the
// switch it concerns (event_switch reads 0 when there is no event). The block takes one
// beat per clock cycle while the output is not stalled. An accepted beat is held in the
// input register, where the per-switch state is read, decoded and written back, and the
// result is loaded into the output register once that register can take it, and is
// presented from there. The state is written back as the result is registered. That
// read-modify-write of the selected switch's state is what sets the rate, so ticks for
// the same switch may follow one another on consecutive beats. While the output beat is
// stalled the input register still accepts one more beat. Settings are written through a
// plain write port (0 enable, 1 event mask, 2 hold threshold, 3 double-press window) and
// should be changed only while no beat is in flight. With events disabled, or a switch
// number at or beyond SWITCH_COUNT, the tick leaves the state untouched and gives an
// output beat with no event. Time differences wrap modulo 2^32.
`include "footswitch_gesture_detector_unit_defines.svh"

module footswitch_gesture_detector_unit
    import fgd_pkg::*;
#(
    parameter int unsigned SWITCH_COUNT = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   switch_select,
    input  logic                   pressed_level,
    input  logic [TIME_W-1:0]      now_ms,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             event_code,
    output logic                   event_switch,

    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned SW_IDX_W = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;

    // Settings.
    logic        enabled_reg;
    fgd_cfg_t    cfg_reg;

    // Input register stage.
    logic              s1_valid_reg;
    logic              s1_sel_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // Output register stage.
    logic        out_valid_reg;
    event_code_t out_code_reg;
    logic        out_switch_reg;

    // Per-switch state.
    sw_state_t   state_reg [SWITCH_COUNT];

    logic                out_ready;
    logic                in_accept;
    logic                commit;
    logic                sel_in_range;
    logic                active;
    logic [SW_IDX_W-1:0] sel_idx;
    sw_state_t           cur_state;
    sw_state_t           upd_state;
    event_code_t         upd_code;
    event_code_t         out_code_next;

    // The output register can take a result when it is empty or being drained.
    assign out_ready = !out_valid_reg || !out_stall;
    assign commit    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign event_code   = out_code_reg;
    assign event_switch = out_switch_reg;

    // Settings port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg                    <= 1'b0;
            cfg_reg.event_mask             <= MASK_RESET;
            cfg_reg.hold_limit_ms          <= THRESHOLD_RESET;
            cfg_reg.double_press_window_ms <= WINDOW_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_IDX_ENABLE:    enabled_reg                    <= cfg_data[0];
                CFG_IDX_MASK:      cfg_reg.event_mask             <= cfg_data[2:0];
                CFG_IDX_THRESHOLD: cfg_reg.hold_limit_ms          <= cfg_data;
                CFG_IDX_WINDOW:    cfg_reg.double_press_window_ms <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register: refills whenever its beat moves on to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sel_reg   <= switch_select;
            s1_level_reg <= pressed_level;
            s1_now_reg   <= now_ms;
        end
    end

    // Selected switch; ticks for a switch that does not exist are ignored.
    assign sel_in_range = 32'(s1_sel_reg) < SWITCH_COUNT;
    assign active       = enabled_reg && sel_in_range;
    assign sel_idx      = SW_IDX_W'(s1_sel_reg);
    assign cur_state    = state_reg[sel_idx];

    fgd_switch_update u_switch_update
    (
        .cur_state (cur_state),
        .cfg       (cfg_reg),
        .level     (s1_level_reg),
        .now       (s1_now_reg),
        .nxt_state (upd_state),
        .code      (upd_code)
    );

    assign out_code_next = active ? upd_code : EV_NONE;

    // State write-back happens on the same edge the result is registered, so the
    // next tick for the same switch already sees the updated state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SWITCH_COUNT; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else if (commit && active)
        begin
            state_reg[sel_idx] <= upd_state;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_code_reg   <= out_code_next;
            out_switch_reg <= (out_code_next != EV_NONE) ? s1_sel_reg : 1'b0;
        end
    end

    // Stalling the input is only ever due to a full input register.
    `FGD_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_reg)
    // A beat held in the input register is not dropped while the output is blocked.
    `FGD_ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_reg && !out_ready, s1_valid_reg)
    // Every beat that leaves the input register shows up at the output.
    `FGD_ASSERT_NEXT(a_commit_reaches_out, clk, rst_n, commit, out_valid_reg)
    // A beat with no event names switch zero.
    `FGD_ASSERT_SAME(a_none_switch_zero, clk, rst_n,
        out_valid_reg && (out_code_reg == EV_NONE), !out_switch_reg)

endmodule
